// ===== design/ppmr_pkg.sv =====
// Shared constants for the pulse-average relay switch.
package ppmr_pkg;

	// Default timer width and averaging depth (each new pulse enters the running average with weight 2**-AVG_SHIFT).
	localparam int COUNTER_BITS_DEF = 12;
	localparam int AVG_SHIFT_DEF    = 3;

	// Threshold registers are always twelve bits wide.
	localparam int THR_BITS = 12;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ON_THRESHOLD  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFF_THRESHOLD = 1'b1;

	// Threshold values after reset, in timer ticks.
	localparam logic [THR_BITS-1:0] ON_THRESHOLD_RST  = 12'd1800;
	localparam logic [THR_BITS-1:0] OFF_THRESHOLD_RST = 12'd1300;

endpackage

// ===== design/ppmr_measure.sv =====
// Edge pairing, pulse width measurement and running average state.
module ppmr_measure #(
	parameter int COUNTER_BITS = ppmr_pkg::COUNTER_BITS_DEF,
	parameter int AVG_SHIFT    = ppmr_pkg::AVG_SHIFT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic                    edge_rising,
	input  logic [COUNTER_BITS-1:0] timer_count,
	output logic                    done_next,
	output logic [COUNTER_BITS-1:0] width_next,
	output logic [COUNTER_BITS-1:0] avg_next
);

	localparam int SUM_BITS = COUNTER_BITS + AVG_SHIFT;

	logic                    expect_rising_q;
	logic [COUNTER_BITS-1:0] rise_time_q;
	logic [COUNTER_BITS-1:0] last_width_q;
	logic [SUM_BITS-1:0]     width_sum_q;
	logic [COUNTER_BITS-1:0] avg_value_q;

	logic                    take_rise;
	logic                    take_fall;
	logic [COUNTER_BITS-1:0] width_new;
	logic [SUM_BITS-1:0]     sum_new;

	// Edges of the unexpected polarity fall through both tests and change nothing.
	assign take_rise = expect_rising_q & edge_rising;
	assign take_fall = ~expect_rising_q & ~edge_rising;

	// Width wraps with the timer; the sum update wraps at its own width.
	assign width_new = timer_count - rise_time_q;
	assign sum_new   = width_sum_q + SUM_BITS'(width_new) - SUM_BITS'(avg_value_q);

	// Values after this item, as seen by the result register.
	assign done_next  = take_fall;
	assign width_next = take_fall ? width_new : last_width_q;
	assign avg_next   = take_fall ? sum_new[SUM_BITS-1:AVG_SHIFT] : avg_value_q;

	// Measurement state advances once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_rising_q <= 1'b1;
			rise_time_q     <= '0;
			last_width_q    <= '0;
			width_sum_q     <= '0;
			avg_value_q     <= '0;
		end else if (step) begin
			if (take_rise) begin
				rise_time_q     <= timer_count;
				expect_rising_q <= 1'b0;
			end else if (take_fall) begin
				last_width_q    <= width_new;
				width_sum_q     <= sum_new;
				avg_value_q     <= sum_new[SUM_BITS-1:AVG_SHIFT];
				expect_rising_q <= 1'b1;
			end
		end
	end

endmodule

// ===== design/ppmr_relay.sv =====
// Threshold registers and the hysteresis relay decision.
module ppmr_relay #(
	parameter int COUNTER_BITS = ppmr_pkg::COUNTER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [ppmr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [ppmr_pkg::THR_BITS-1:0]     cfg_data,
	input  logic                              step,
	input  logic [COUNTER_BITS-1:0]           avg_next,
	output logic                              relay_next
);

	localparam int CMP_BITS = (COUNTER_BITS > ppmr_pkg::THR_BITS) ?
		COUNTER_BITS : ppmr_pkg::THR_BITS;

	logic [ppmr_pkg::THR_BITS-1:0] on_threshold_q;
	logic [ppmr_pkg::THR_BITS-1:0] off_threshold_q;
	logic                          relay_state_q;

	logic [CMP_BITS-1:0] avg_ext;
	logic [CMP_BITS-1:0] on_ext;
	logic [CMP_BITS-1:0] off_ext;

	assign avg_ext = CMP_BITS'(avg_next);
	assign on_ext  = CMP_BITS'(on_threshold_q);
	assign off_ext = CMP_BITS'(off_threshold_q);

	// The off test is applied last, so it wins when both hold.
	always_comb begin
		relay_next = relay_state_q;
		if (avg_ext > on_ext) begin
			relay_next = 1'b1;
		end
		if (avg_ext < off_ext) begin
			relay_next = 1'b0;
		end
	end

	// Register writes from the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_threshold_q  <= ppmr_pkg::ON_THRESHOLD_RST;
			off_threshold_q <= ppmr_pkg::OFF_THRESHOLD_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				ppmr_pkg::REG_ON_THRESHOLD: begin
					on_threshold_q <= cfg_data;
				end
				ppmr_pkg::REG_OFF_THRESHOLD: begin
					off_threshold_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// The relay test runs on every item, whatever its polarity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_state_q <= 1'b0;
		end else if (step) begin
			relay_state_q <= relay_next;
		end
	end

endmodule

// ===== design/ppm_pulse_average_relay_switch_unit.sv =====
// Top level of the pulse-average relay switch: input register, datapath, result register.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------------
//  s_       | in        | s_tvalid / s_tready     | tuser: edge_rising; tdata: timer_count
//  m_       | out       | m_tvalid / m_tready     | tuser: sample_done; tdata: measured width,
//           |           |                         |   mean width, relay level
//  cfg_     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data (threshold value)
//
// One item per cycle sustained while the output is not stalled; an item passes through the input
// register and then the result register, from which it is offered.
// The work sits between the input register and the result register: one subtract for the
// width, one add/subtract for the sum and two compares for the relay.
// Reset clears the handshake state, the measurement state and loads the default thresholds.
// A stall on the output holds the result; the input register still takes one more edge if it is empty.
module ppm_pulse_average_relay_switch_unit #(
	parameter int COUNTER_BITS = ppmr_pkg::COUNTER_BITS_DEF,
	parameter int AVG_SHIFT    = ppmr_pkg::AVG_SHIFT_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	input  logic                                        s_tuser,  // edge_rising
	input  logic [((COUNTER_BITS+7)/8)*8-1:0]           s_tdata,  // timer_count
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	output logic                                        m_tuser,  // sample_done
	// measured width, mean width, relay level, zero fill
	output logic [((2*COUNTER_BITS+8)/8)*8-1:0]         m_tdata,
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic [ppmr_pkg::CFG_IDX_BITS-1:0]           cfg_index,
	input  logic [ppmr_pkg::THR_BITS-1:0]               cfg_data
);

	localparam int M_DW   = ((2*COUNTER_BITS+8)/8)*8;

	logic                    valid_s1;
	logic                    rising_s1;
	logic [COUNTER_BITS-1:0] count_s1;

	logic                    out_valid_q;
	logic                    done_q;
	logic [COUNTER_BITS-1:0] width_q;
	logic [COUNTER_BITS-1:0] avg_q;
	logic                    relay_q;

	logic                    advance;
	logic                    done_next;
	logic [COUNTER_BITS-1:0] width_next;
	logic [COUNTER_BITS-1:0] avg_next;
	logic                    relay_next;

	// An item moves into the result register when that register is free or being emptied.
	assign advance   = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready  = ~valid_s1 | advance;
	assign cfg_ready = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rising_s1 <= s_tuser;
			count_s1  <= s_tdata[COUNTER_BITS-1:0];
		end
	end

	ppmr_measure #(
		.COUNTER_BITS(COUNTER_BITS),
		.AVG_SHIFT   (AVG_SHIFT)
	) u_measure (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.edge_rising(rising_s1),
		.timer_count(count_s1),
		.done_next  (done_next),
		.width_next (width_next),
		.avg_next   (avg_next)
	);

	ppmr_relay #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_relay (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.avg_next  (avg_next),
		.relay_next(relay_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q  <= done_next;
			width_q <= width_next;
			avg_q   <= avg_next;
			relay_q <= relay_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = done_q;
	assign m_tdata  = M_DW'({relay_q, avg_q, width_q});

endmodule

// ===== design/ppmr_checker.sv =====
// Port-level checker for the pulse-average relay switch, bound to the top level.
module ppmr_checker #(
	parameter int COUNTER_BITS = ppmr_pkg::COUNTER_BITS_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                s_tuser,
	input logic [((COUNTER_BITS+7)/8)*8-1:0]   s_tdata,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic                                m_tuser,
	input logic [((2*COUNTER_BITS+8)/8)*8-1:0] m_tdata
);

	logic                      m_xfer;
	logic [COUNTER_BITS-1:0]   prev_width_q;
	logic [COUNTER_BITS-1:0]   prev_avg_q;

	assign m_xfer = m_tvalid & m_tready;

	// Width and average of the last result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_width_q <= '0;
			prev_avg_q   <= '0;
		end else if (m_xfer) begin
			prev_width_q <= m_tdata[COUNTER_BITS-1:0];
			prev_avg_q   <= m_tdata[2*COUNTER_BITS-1:COUNTER_BITS];
		end
	end

	// A stalled edge stays offered with its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tuser) && $stable(s_tdata))
		else $error("input edge changed while stalled");

	// A stalled result stays offered.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// The input side only stalls behind a stalled output.
	a_in_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// An edge that completes no measurement repeats the held width and average.
	a_no_sample_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer && !m_tuser |->
			m_tdata[COUNTER_BITS-1:0] == prev_width_q &&
			m_tdata[2*COUNTER_BITS-1:COUNTER_BITS] == prev_avg_q)
		else $error("width or average changed without a completed pulse");

endmodule

bind ppm_pulse_average_relay_switch_unit ppmr_checker #(
	.COUNTER_BITS(COUNTER_BITS)
) u_ppmr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata)
);
